FILE: design/pfpc_pkg.sv
// shared types and constants for the pressure frame parser with calibration
// no dependencies; used by the framer, the calibration stage and the top level
package pfpc_pkg;

  // field widths fixed by the sensor link
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PRESS_W    = 16;
  localparam int unsigned ACC_W      = 20;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned POS_W      = 2;
  localparam int unsigned OUT_DATA_W = 40;

  // defaults
  localparam int unsigned CAL_SAMPLES_DEF = 10;
  localparam logic [PRESS_W-1:0] CAL_OFFSET_RST = 16'd50;

  // byte position within a frame
  localparam logic [POS_W-1:0] POS_HIGH  = 2'd0;
  localparam logic [POS_W-1:0] POS_LOW   = 2'd1;
  localparam logic [POS_W-1:0] POS_CHECK = 2'd2;

  // one completed frame handed from the framer to the calibration stage
  typedef struct packed {
    logic               ok;
    logic [PRESS_W-1:0] pressure;
    logic               cal_hit;
    logic [ACC_W-1:0]   acc;
  } frame_rec_t;

endpackage

FILE: design/pfpc_framer.sv
// byte framer: groups bytes into high, low, checksum frames and keeps the start-up sum
// depends on pfpc_pkg
module pfpc_framer #(
  parameter int unsigned CAL_SAMPLES = pfpc_pkg::CAL_SAMPLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         accept,
  input  logic [pfpc_pkg::BYTE_W-1:0]  rx_byte,
  output logic                         rec_valid,
  output pfpc_pkg::frame_rec_t         rec
);

  localparam logic [pfpc_pkg::CNT_W-1:0] SAMPLES = pfpc_pkg::CNT_W'(CAL_SAMPLES);

  logic [pfpc_pkg::POS_W-1:0]   byte_position;
  logic [pfpc_pkg::BYTE_W-1:0]  high_byte;
  logic [pfpc_pkg::BYTE_W-1:0]  low_byte;
  logic [pfpc_pkg::CNT_W-1:0]   valid_frames_seen;
  logic [pfpc_pkg::ACC_W-1:0]   cal_accumulator;
  logic [pfpc_pkg::PRESS_W-1:0] last_pressure;

  logic                         check_pos;
  logic                         ok;
  logic                         take_cal;
  logic [pfpc_pkg::BYTE_W-1:0]  sum8;
  logic [pfpc_pkg::PRESS_W-1:0] value;
  logic [pfpc_pkg::CNT_W-1:0]   cnt_next;
  logic [pfpc_pkg::ACC_W-1:0]   acc_next;

  // checksum and start-up sum for the byte on the input
  always_comb begin
    check_pos = (byte_position == pfpc_pkg::POS_CHECK);
    sum8      = high_byte + low_byte;
    ok        = (sum8 == rx_byte);
    value     = {high_byte, low_byte};
    take_cal  = ok && (valid_frames_seen < SAMPLES);
    cnt_next  = valid_frames_seen + 1'b1;
    acc_next  = cal_accumulator + pfpc_pkg::ACC_W'(value);
  end

  // frame state, updated on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= pfpc_pkg::POS_HIGH;
      high_byte         <= '0;
      low_byte          <= '0;
      valid_frames_seen <= '0;
      cal_accumulator   <= '0;
      last_pressure     <= '0;
    end else if (accept) begin
      unique case (byte_position)
        pfpc_pkg::POS_LOW: begin
          low_byte      <= rx_byte;
          byte_position <= pfpc_pkg::POS_CHECK;
        end
        pfpc_pkg::POS_CHECK: begin
          byte_position <= pfpc_pkg::POS_HIGH;
          if (ok) begin
            last_pressure <= value;
          end
          if (take_cal) begin
            valid_frames_seen <= cnt_next;
            cal_accumulator   <= acc_next;
          end
        end
        default: begin
          // the unused position behaves like the high byte position
          high_byte     <= rx_byte;
          byte_position <= pfpc_pkg::POS_LOW;
        end
      endcase
    end
  end

  // frame record register
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (adv) begin
      rec_valid <= accept && check_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec.ok       <= ok;
      rec.pressure <= ok ? value : last_pressure;
      rec.cal_hit  <= take_cal && (cnt_next == SAMPLES);
      rec.acc      <= acc_next;
    end
  end

endmodule

FILE: design/pfpc_calib.sv
// calibration stage: reciprocal multiply for the average, offset and saturation,
// and the result register; depends on pfpc_pkg
module pfpc_calib #(
  parameter int unsigned CAL_SAMPLES = pfpc_pkg::CAL_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          rec_valid,
  input  pfpc_pkg::frame_rec_t          rec,
  input  logic [pfpc_pkg::PRESS_W-1:0]  cal_offset,
  output logic                          out_valid,
  output logic                          frame_ok,
  output logic [pfpc_pkg::PRESS_W-1:0]  pressure,
  output logic [pfpc_pkg::PRESS_W-1:0]  cal_value,
  output logic                          cal_ready
);

  // sum / CAL_SAMPLES as (sum * RECIP) >> SHIFT, exact for every sum below 2**ACC_W
  localparam int unsigned SHIFT   = pfpc_pkg::ACC_W + $clog2(CAL_SAMPLES);
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = pfpc_pkg::ACC_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  logic                         mul_valid;
  pfpc_pkg::frame_rec_t         mul_rec;
  logic [PROD_W-1:0]            prod;
  logic [pfpc_pkg::ACC_W-1:0]   avg;
  logic [pfpc_pkg::ACC_W-1:0]   offset_ext;
  logic [pfpc_pkg::PRESS_W-1:0] cal_sat;

  // multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (adv) begin
      mul_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mul_rec <= rec;
      prod    <= PROD_W'(rec.acc) * PROD_W'(RECIP);
    end
  end

  // offset subtraction, saturating at zero
  always_comb begin
    avg        = prod[SHIFT +: pfpc_pkg::ACC_W];
    offset_ext = pfpc_pkg::ACC_W'(cal_offset);
    cal_sat    = (avg >= offset_ext) ? pfpc_pkg::PRESS_W'(avg - offset_ext) : '0;
  end

  // result register; the calibration state lives here and is sticky
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cal_value <= '0;
      cal_ready <= 1'b0;
    end else if (adv) begin
      out_valid <= mul_valid;
      if (mul_valid && mul_rec.cal_hit) begin
        cal_value <= cal_sat;
        cal_ready <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mul_valid) begin
      frame_ok <= mul_rec.ok;
      pressure <= mul_rec.pressure;
    end
  end

endmodule

FILE: design/pressure_frame_parser_calibrate_core.sv
// Pressure frame parser with start-up zero-point calibration.
// Input stream: one received serial byte per item on s_axis. Bytes are grouped
// into frames of high byte, low byte and an 8-bit sum checksum.
// Output stream: one item per completed frame on m_axis, carrying the checksum
// flag, the latest valid pressure and the calibration zero point with its flag.
// The first CAL_SAMPLES valid frames are averaged; the average less cal_offset,
// floored at zero, becomes the calibration. cal_offset is written through
// cfg_wr_en / cfg_wr_data and is sampled when calibration completes.
// Throughput: one byte per cycle while the receiver does not stall. The framer
// updates on each accepted byte and the divide by CAL_SAMPLES is a reciprocal
// multiply with its own pipeline stage. A checksum byte's result passes through the
// framer's record register, the multiply register and then the result register.
// Reset (rst, synchronous) clears framing, the start-up sum and calibration and
// sets cal_offset to 50; no clearing pass is needed.
// When the receiver stalls the result is held in the output register and the
// pipeline freezes; s_axis_tready drops only while a result waits unaccepted.
// depends on pfpc_pkg, pfpc_framer, pfpc_calib
module pressure_frame_parser_calibrate_core #(
  parameter int unsigned CAL_SAMPLES = pfpc_pkg::CAL_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // rx_byte [7:0]
  input  logic [pfpc_pkg::BYTE_W-1:0]       s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // frame_ok [0], pressure [16:1], cal_value [32:17], cal_ready [33], zeros [39:34]
  output logic [pfpc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_wr_en,
  input  logic [pfpc_pkg::PRESS_W-1:0]      cfg_wr_data
);

  logic                         adv;
  logic                         accept;
  logic                         rec_valid;
  pfpc_pkg::frame_rec_t         rec;
  logic [pfpc_pkg::PRESS_W-1:0] cal_offset;
  logic                         out_valid;
  logic                         frame_ok;
  logic [pfpc_pkg::PRESS_W-1:0] pressure;
  logic [pfpc_pkg::PRESS_W-1:0] cal_value;
  logic                         cal_ready;

  // pipeline moves whenever the output register is free or being taken
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // offset register
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_offset <= pfpc_pkg::CAL_OFFSET_RST;
    end else if (cfg_wr_en) begin
      cal_offset <= cfg_wr_data;
    end
  end

  pfpc_framer #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_framer (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .accept    (accept),
    .rx_byte   (s_axis_tdata),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  pfpc_calib #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_calib (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .rec_valid  (rec_valid),
    .rec        (rec),
    .cal_offset (cal_offset),
    .out_valid  (out_valid),
    .frame_ok   (frame_ok),
    .pressure   (pressure),
    .cal_value  (cal_value),
    .cal_ready  (cal_ready)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, cal_ready, cal_value, pressure, frame_ok};

endmodule

FILE: design/pfpc_checker.sv
// port-level checks for the pressure frame parser core, bound to the top level
// depends on pfpc_pkg and pressure_frame_parser_calibrate_core
module pfpc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic [pfpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready
);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input is never refused while the output register is empty
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // calibration flag is sticky outside reset
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(m_axis_tdata[33]))
    else $error("calibration flag dropped");

  // no calibration value before calibration is complete
  a_cal_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[32:17] == 16'd0)
    else $error("calibration value before ready");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
    else $error("padding bits set");

endmodule

bind pressure_frame_parser_calibrate_core pfpc_checker u_pfpc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

FILE: bench/tb_top.sv
// self-checking bench for pressure_frame_parser_calibrate_core: byte framing,
// checksum flag, latest pressure and start-up zero-point calibration
// depends on pfpc_pkg and the core with its sub-blocks; needs no other file
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CAL_N     = pfpc_pkg::CAL_SAMPLES_DEF;
  localparam int unsigned SETTLE    = 8;
  localparam int unsigned CYC_LIMIT = 300000;

  // one expected result per completed frame
  typedef struct packed {
    logic                         ok;
    logic [pfpc_pkg::PRESS_W-1:0] press;
    logic [pfpc_pkg::PRESS_W-1:0] zero;
    logic                         ready;
  } frame_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [pfpc_pkg::BYTE_W-1:0]     s_axis_tdata = '0;    // rx_byte [7:0]
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [pfpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // frame_ok [0], pressure [16:1],
                                                         // cal_value [32:17], cal_ready [33]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [pfpc_pkg::PRESS_W-1:0]    cfg_wr_data = '0;

  // own copy of the parser state and the offset register
  logic [pfpc_pkg::POS_W-1:0]   frm_pos;
  logic [pfpc_pkg::BYTE_W-1:0]  frm_hi;
  logic [pfpc_pkg::BYTE_W-1:0]  frm_lo;
  logic [pfpc_pkg::CNT_W-1:0]   valid_cnt;
  logic [pfpc_pkg::ACC_W-1:0]   start_sum;
  logic [pfpc_pkg::PRESS_W-1:0] zero_point;
  logic                         zero_ready;
  logic [pfpc_pkg::PRESS_W-1:0] latest_press;
  logic [pfpc_pkg::PRESS_W-1:0] offset_reg;

  frame_result_t expected_frames[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned bad_frames = 0;
  int unsigned cycle_cnt = 0;

  pressure_frame_parser_calibrate_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_frames.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // predictor: advance the framer by one accepted byte
  task automatic track_byte(input logic [pfpc_pkg::BYTE_W-1:0] b);
    frame_result_t                r;
    logic [pfpc_pkg::BYTE_W-1:0]  sum8;
    logic [pfpc_pkg::PRESS_W-1:0] word;
    logic [pfpc_pkg::ACC_W-1:0]   avg;
    case (frm_pos)
      pfpc_pkg::POS_LOW: begin
        frm_lo  = b;
        frm_pos = pfpc_pkg::POS_CHECK;
      end
      pfpc_pkg::POS_CHECK: begin
        frm_pos = pfpc_pkg::POS_HIGH;
        sum8    = frm_hi + frm_lo;
        word    = {frm_hi, frm_lo};
        r.ok    = (sum8 == b);
        if (r.ok) begin
          latest_press = word;
          if (valid_cnt < CAL_N) begin
            start_sum = start_sum + word;
            valid_cnt = valid_cnt + 1'b1;
            if (valid_cnt == CAL_N) begin
              avg        = pfpc_pkg::ACC_W'(start_sum / CAL_N);
              zero_point = (avg >= offset_reg) ?
                           pfpc_pkg::PRESS_W'(avg - offset_reg) : '0;
              zero_ready = 1'b1;
            end
          end
        end
        r.press = latest_press;
        r.zero  = zero_point;
        r.ready = zero_ready;
        expected_frames.push_back(r);
      end
      // high byte; an unused position behaves the same
      default: begin
        frm_hi  = b;
        frm_pos = pfpc_pkg::POS_LOW;
      end
    endcase
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result(input logic [pfpc_pkg::OUT_DATA_W-1:0] d);
    frame_result_t e;
    frames_checked++;
    if (expected_frames.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", d));
    end else begin
      e = expected_frames.pop_front();
      if (d[0] !== e.ok)
        report_mismatch($sformatf("frame_ok %b, want %b", d[0], e.ok));
      if (d[16:1] !== e.press)
        report_mismatch($sformatf("pressure %h, want %h", d[16:1], e.press));
      if (d[32:17] !== e.zero)
        report_mismatch($sformatf("cal_value %h, want %h", d[32:17], e.zero));
      if (d[33] !== e.ready)
        report_mismatch($sformatf("cal_ready %b, want %b", d[33], e.ready));
    end
  endtask

  // receiver side: check accepted items, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result(m_axis_tdata);
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // send one byte, with a random gap before it
  task automatic send_byte(input logic [pfpc_pkg::BYTE_W-1:0] b);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    track_byte(b);
  endtask

  task automatic send_frame(input logic [pfpc_pkg::BYTE_W-1:0] hi,
                            input logic [pfpc_pkg::BYTE_W-1:0] lo,
                            input logic good);
    logic [pfpc_pkg::BYTE_W-1:0] ck;
    ck = hi + lo;
    if (!good) begin
      ck = ck ^ pfpc_pkg::BYTE_W'($urandom_range(1, 255));
      bad_frames++;
    end
    send_byte(hi);
    send_byte(lo);
    send_byte(ck);
  endtask

  // drain all results, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_offset(input logic [pfpc_pkg::PRESS_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    offset_reg  = v;
  endtask

  // bad checksums before any valid frame: pressure and calibration stay zero
  task automatic test_bad_before_valid();
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 1'b0);
    settle();
  endtask

  // start-up calibration, with offset writes while it is in progress
  task automatic test_calibration();
    logic [pfpc_pkg::PRESS_W-1:0] vals[CAL_N];
    logic [pfpc_pkg::ACC_W-1:0]   avg;
    logic [pfpc_pkg::PRESS_W-1:0] off;
    vals[0] = 16'h0000;
    vals[1] = 16'hFFFF;
    vals[2] = 16'hFF00;
    vals[3] = 16'h00FF;
    vals[4] = 16'h8001;
    for (int i = 5; i < CAL_N; i++) vals[i] = pfpc_pkg::PRESS_W'($urandom);
    for (int i = 0; i < CAL_N; i++) begin
      if (i == 3) write_offset(16'hFFFF);
      if (i == 6) write_offset(16'h0000);
      // last sample: pick an offset either above the average (floor at zero) or at or below it
      if (i == CAL_N - 1) begin
        avg = pfpc_pkg::ACC_W'((start_sum + vals[i]) / CAL_N);
        if ($urandom_range(0, 1) == 1 && avg < 20'hFFFF)
          off = pfpc_pkg::PRESS_W'($urandom_range(avg + 1, 16'hFFFF));
        else
          off = pfpc_pkg::PRESS_W'($urandom_range(0, avg));
        write_offset(off);
      end
      send_frame(vals[i][15:8], vals[i][7:0], 1'b1);
      // a bad frame mid-way must not count
      if (i == 4) send_frame(vals[i][15:8], vals[i][7:0], 1'b0);
    end
    settle();
  endtask

  // later offset writes leave the finished calibration alone
  task automatic test_after_calibration();
    write_offset(16'h0000);
    send_frame(8'h01, 8'h02, 1'b1);
    send_frame(8'hAA, 8'h55, 1'b0);
    write_offset(16'hFFFF);
    send_frame(8'hFF, 8'hFF, 1'b1);
    send_frame(8'h80, 8'h80, 1'b1);
    settle();
  endtask

  // random traffic: mostly well-formed frames, some bad checksums and stray bytes
  task automatic test_random(input int unsigned idle, input int unsigned stall,
                             input int unsigned n_bytes);
    int unsigned kind;
    idle_pct  = idle;
    stall_pct = stall;
    while (bytes_sent < n_bytes) begin
      kind = $urandom_range(0, 19);
      if (kind < 14)
        send_frame(pfpc_pkg::BYTE_W'($urandom), pfpc_pkg::BYTE_W'($urandom), 1'b1);
      else if (kind < 18)
        send_frame(pfpc_pkg::BYTE_W'($urandom), pfpc_pkg::BYTE_W'($urandom), 1'b0);
      else
        send_byte(pfpc_pkg::BYTE_W'($urandom));
    end
    settle();
    write_offset(pfpc_pkg::PRESS_W'($urandom));
  endtask

  initial begin
    frm_pos      = pfpc_pkg::POS_HIGH;
    frm_hi       = '0;
    frm_lo       = '0;
    valid_cnt    = '0;
    start_sum    = '0;
    zero_point   = '0;
    zero_ready   = 1'b0;
    latest_press = '0;
    offset_reg   = pfpc_pkg::CAL_OFFSET_RST;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_bad_before_valid();
    test_calibration();
    test_after_calibration();
    test_random(0, 0, bytes_sent + 325);
    test_random(51, 0, bytes_sent + 325);
    test_random(0, 51, bytes_sent + 325);
    test_random(18, 18, bytes_sent + 325);

    settle();
    $display("sent %0d bytes, checked %0d frames (%0d with bad checksum)",
             bytes_sent, frames_checked, bad_frames);
    $display("calibration %0s at %h, %0d mismatches",
             zero_ready ? "done" : "not done", zero_point, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pfpc_pkg.sv
design/pfpc_framer.sv
design/pfpc_calib.sv
design/pressure_frame_parser_calibrate_core.sv
design/pfpc_checker.sv
bench/tb_top.sv
